// File: design/assert_macros.svh
// Assertion macros shared by the Morse decoder RTL.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define MCD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcd assertion failed");
// Check a property on every rising edge, reset included
`define MCD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mcd assertion failed");
`else
`define MCD_ASSERT(name, clk, rst_n, prop)
`define MCD_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: design/mcd_pkg.sv
// Shared types, character codes and the Morse lookup table of the decoder.
// No dependencies; the front end, queue, back end and top refer to it by scoped names.
`default_nettype none
package mcd_pkg;

  localparam int MAX_SYMBOLS_DEF     = 8;
  localparam int LINE_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH         = 4;

  localparam int CHAR_W = 8;
  localparam int CODE_W = 8;
  localparam int LEN_W  = 4;
  localparam int LINE_W = 16;

  // Input and output character codes
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;

  // Word that follows a closed code
  typedef enum logic [1:0] {
    TR_NONE,
    TR_SPACE,
    TR_NEWLINE
  } trail_t;

  // One job handed from the front end to the back end
  typedef struct packed {
    logic              has_code;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    trail_t            trail;
    logic [LINE_W-1:0] line;
  } job_t;

  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] ch;
  } lookup_t;

  // Morse table: dot 0, dash 1, newest symbol in the lsb
  function automatic lookup_t morse_lookup(logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
    lookup_t r;
    r.hit = 1'b1;
    r.ch  = CH_STAR;
    unique case ({len, bits})
      {4'd2, 8'd1}:  r.ch = "a";
      {4'd4, 8'd8}:  r.ch = "b";
      {4'd4, 8'd10}: r.ch = "c";
      {4'd3, 8'd4}:  r.ch = "d";
      {4'd1, 8'd0}:  r.ch = "e";
      {4'd4, 8'd2}:  r.ch = "f";
      {4'd3, 8'd6}:  r.ch = "g";
      {4'd4, 8'd0}:  r.ch = "h";
      {4'd2, 8'd0}:  r.ch = "i";
      {4'd4, 8'd7}:  r.ch = "j";
      {4'd3, 8'd5}:  r.ch = "k";
      {4'd4, 8'd4}:  r.ch = "l";
      {4'd2, 8'd3}:  r.ch = "m";
      {4'd2, 8'd2}:  r.ch = "n";
      {4'd3, 8'd7}:  r.ch = "o";
      {4'd4, 8'd6}:  r.ch = "p";
      {4'd4, 8'd13}: r.ch = "q";
      {4'd3, 8'd2}:  r.ch = "r";
      {4'd3, 8'd0}:  r.ch = "s";
      {4'd1, 8'd1}:  r.ch = "t";
      {4'd3, 8'd1}:  r.ch = "u";
      {4'd4, 8'd1}:  r.ch = "v";
      {4'd3, 8'd3}:  r.ch = "w";
      {4'd4, 8'd9}:  r.ch = "x";
      {4'd4, 8'd11}: r.ch = "y";
      {4'd4, 8'd12}: r.ch = "z";
      {4'd5, 8'd15}: r.ch = "1";
      {4'd5, 8'd7}:  r.ch = "2";
      {4'd5, 8'd3}:  r.ch = "3";
      {4'd5, 8'd1}:  r.ch = "4";
      {4'd5, 8'd0}:  r.ch = "5";
      {4'd5, 8'd16}: r.ch = "6";
      {4'd5, 8'd24}: r.ch = "7";
      {4'd5, 8'd28}: r.ch = "8";
      {4'd5, 8'd30}: r.ch = "9";
      {4'd5, 8'd31}: r.ch = "0";
      {4'd6, 8'd51}: r.ch = ",";
      {4'd6, 8'd21}: r.ch = ".";
      {4'd6, 8'd12}: r.ch = "?";
      {4'd6, 8'd33}: r.ch = "-";
      {4'd6, 8'd56}: r.ch = ":";
      {4'd8, 8'd0}:  r.ch = "#";
      default: begin
        r.hit = 1'b0;
        r.ch  = CH_STAR;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/mcd_front.sv
// Front end: accepts bytes, builds the open Morse code and counts lines.
// Emits one job per byte that causes output. Depends on mcd_pkg.
`default_nettype none
module mcd_front #(
  parameter int MAX_SYMBOLS     = mcd_pkg::MAX_SYMBOLS_DEF,
  parameter int LINE_COUNT_BITS = mcd_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [mcd_pkg::CHAR_W-1:0]  in_char,
  input  wire logic                        q_full,
  output logic                             in_stall,
  output logic                             push,
  output mcd_pkg::job_t                    push_job
);

  localparam int CLEN_W = $clog2(MAX_SYMBOLS + 2);
  localparam logic [CLEN_W-1:0] LEN_MAX  = CLEN_W'(MAX_SYMBOLS);
  localparam logic [CLEN_W-1:0] LEN_OVER = CLEN_W'(MAX_SYMBOLS + 1);

  logic [mcd_pkg::CODE_W-1:0] code_bits_r, code_bits_nxt;
  logic [CLEN_W-1:0]          code_len_r, code_len_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;
  logic                       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte and update the open code
  always_comb begin
    code_bits_nxt      = code_bits_r;
    code_len_nxt       = code_len_r;
    line_nxt           = line_r;
    push               = 1'b0;
    push_job.has_code  = (code_len_r != '0);
    push_job.code_bits = code_bits_r;
    push_job.code_len  = mcd_pkg::LEN_W'(code_len_r);
    push_job.trail     = mcd_pkg::TR_NONE;
    push_job.line      = mcd_pkg::LINE_W'(line_r);
    if (accept) begin
      unique case (in_char) inside
        mcd_pkg::CH_DOT, mcd_pkg::CH_DASH: begin
          if (code_len_r < LEN_MAX) begin
            code_bits_nxt = {code_bits_r[mcd_pkg::CODE_W-2:0], in_char == mcd_pkg::CH_DASH};
            code_len_nxt  = code_len_r + CLEN_W'(1);
          end else begin
            code_len_nxt = LEN_OVER;
          end
        end
        mcd_pkg::CH_SPACE: begin
          push          = (code_len_r != '0);
          code_bits_nxt = '0;
          code_len_nxt  = '0;
        end
        mcd_pkg::CH_SLASH: begin
          push           = 1'b1;
          push_job.trail = mcd_pkg::TR_SPACE;
          code_bits_nxt  = '0;
          code_len_nxt   = '0;
        end
        mcd_pkg::CH_NL: begin
          push           = 1'b1;
          push_job.trail = mcd_pkg::TR_NEWLINE;
          code_bits_nxt  = '0;
          code_len_nxt   = '0;
          if (line_r != '1) begin
            line_nxt = line_r + LINE_COUNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold code and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bits_r <= '0;
      code_len_r  <= '0;
      line_r      <= LINE_COUNT_BITS'(1);
    end else begin
      code_bits_r <= code_bits_nxt;
      code_len_r  <= code_len_nxt;
      line_r      <= line_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/mcd_queue.sv
// Short job queue between the front end and the back end.
// Depends on mcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mcd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  mcd_pkg::job_t      push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output mcd_pkg::job_t      head_job
);

  localparam int DEPTH = mcd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mcd_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  `MCD_ASSERT(a_no_overflow, clk, rst_n, !(push && full))
  `MCD_ASSERT(a_no_underflow, clk, rst_n, !(pop && !head_valid))
  `MCD_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

// File: design/mcd_back.sv
// Back end: looks up each closed code and delivers one or two result words.
// Depends on mcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mcd_back #(
  parameter int MAX_SYMBOLS = mcd_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  mcd_pkg::job_t                    head_job,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mcd_pkg::CHAR_W-1:0]       out_char,
  output logic                             out_invalid,
  output logic [mcd_pkg::LINE_W-1:0]       out_line_number,
  output logic                             out_last
);

  localparam logic [mcd_pkg::LEN_W-1:0] LEN_MAX = mcd_pkg::LEN_W'(MAX_SYMBOLS);

  logic                        out_valid_r, out_valid_nxt;
  logic [mcd_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        inv_r, inv_nxt;
  logic [mcd_pkg::LINE_W-1:0]  line_r, line_nxt;
  logic                        last_r, last_nxt;
  logic                        pend_r, pend_nxt;
  mcd_pkg::trail_t             pend_trail_r, pend_trail_nxt;
  logic [mcd_pkg::LINE_W-1:0]  pend_line_r, pend_line_nxt;
  logic                        load;
  mcd_pkg::lookup_t            hit;
  logic [mcd_pkg::CHAR_W-1:0]  head_trail_ch;
  logic [mcd_pkg::CHAR_W-1:0]  pend_trail_ch;

  assign load = !out_valid_r || !out_stall;
  assign hit  = mcd_pkg::morse_lookup(head_job.code_len, head_job.code_bits);

  function automatic logic [mcd_pkg::CHAR_W-1:0] trail_char(mcd_pkg::trail_t t);
    logic [mcd_pkg::CHAR_W-1:0] c;
    unique case (t)
      mcd_pkg::TR_NEWLINE: c = mcd_pkg::CH_NL;
      default:             c = mcd_pkg::CH_SPACE;
    endcase
    return c;
  endfunction

  assign head_trail_ch = trail_char(head_job.trail);
  assign pend_trail_ch = trail_char(pend_trail_r);

  // Fill the output register: pending trailer first, then the queue head
  always_comb begin
    out_valid_nxt  = out_valid_r;
    char_nxt       = char_r;
    inv_nxt        = inv_r;
    line_nxt       = line_r;
    last_nxt       = last_r;
    pend_nxt       = pend_r;
    pend_trail_nxt = pend_trail_r;
    pend_line_nxt  = pend_line_r;
    pop            = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        char_nxt      = pend_trail_ch;
        inv_nxt       = 1'b0;
        line_nxt      = pend_line_r;
        last_nxt      = 1'b1;
        pend_nxt      = 1'b0;
      end else if (head_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        line_nxt      = head_job.line;
        if (head_job.has_code) begin
          if (hit.hit && head_job.code_len <= LEN_MAX) begin
            char_nxt = hit.ch;
            inv_nxt  = 1'b0;
          end else begin
            char_nxt = mcd_pkg::CH_STAR;
            inv_nxt  = 1'b1;
          end
          last_nxt       = (head_job.trail == mcd_pkg::TR_NONE);
          pend_nxt       = (head_job.trail != mcd_pkg::TR_NONE);
          pend_trail_nxt = head_job.trail;
          pend_line_nxt  = head_job.line;
        end else begin
          char_nxt = head_trail_ch;
          inv_nxt  = 1'b0;
          last_nxt = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    char_r       <= char_nxt;
    inv_r        <= inv_nxt;
    line_r       <= line_nxt;
    last_r       <= last_nxt;
    pend_trail_r <= pend_trail_nxt;
    pend_line_r  <= pend_line_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = char_r;
  assign out_invalid     = inv_r;
  assign out_line_number = line_r;
  assign out_last        = last_r;

  `MCD_ASSERT(a_pend_has_word, clk, rst_n, pend_r |-> out_valid_r)
  `MCD_ASSERT(a_pend_not_last, clk, rst_n, (pend_r && out_valid_r) |-> !last_r)
  `MCD_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid_r && !pend_r))

endmodule
`default_nettype wire

// File: design/morse_code_decoder.sv
// Top level of the Morse code decoder: front end, job queue, back end.
// Depends on mcd_pkg, mcd_front, mcd_queue and mcd_back.
//
// Takes one byte per cycle while the four-entry job queue has room. Dots and
// dashes extend the open code; space, slash and newline close it. Bytes that
// produce output become one job each. The back end delivers one result word
// per cycle while out_stall is low, so a byte that yields two words (a closed
// code followed by a space or newline) takes up the single output register
// for both of them, one after the other. The first word passes through the
// job queue and then the output register before it is on the outputs.
// in_stall rises only when the queue is full.
`default_nettype none
module morse_code_decoder #(
  parameter int MAX_SYMBOLS     = mcd_pkg::MAX_SYMBOLS_DEF,
  parameter int LINE_COUNT_BITS = mcd_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mcd_pkg::CHAR_W-1:0]  in_char,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mcd_pkg::CHAR_W-1:0]       out_char,
  output logic                             out_invalid,
  output logic [mcd_pkg::LINE_W-1:0]       out_line_number,
  output logic                             out_last
);

  logic          q_full;
  logic          push;
  mcd_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  mcd_pkg::job_t head_job;

  mcd_front #(
    .MAX_SYMBOLS     (MAX_SYMBOLS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_char  (in_char),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job)
  );

  mcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mcd_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_invalid     (out_invalid),
    .out_line_number (out_line_number),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
